// ===== rtl/isr_pkg.sv =====
package isr_pkg;

	// Width of the input value
	localparam int IN_WIDTH   = 31;
	// Number of root bits the digit recurrence settles (one per stage)
	localparam int ROOT_BITS  = (IN_WIDTH + 1) / 2;
	// Input padded to an even number of bits, two bits consumed per stage
	localparam int PAD_WIDTH  = 2 * ROOT_BITS;
	// Running remainder width: 4*rem + 3 stays below 2^(ROOT_BITS+2)
	localparam int REM_WIDTH  = ROOT_BITS + 2;
	// Width of the result field
	localparam int ROOT_WIDTH = 16;

endpackage

// ===== rtl/isr_if.sv =====
interface isr_in_if;
	import isr_pkg::*;

	logic                valid;
	logic                ready;
	logic [IN_WIDTH-1:0] value;

	modport source(output valid, output value, input ready);
	modport sink(input valid, input value, output ready);
endinterface

interface isr_out_if;
	import isr_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [ROOT_WIDTH-1:0] root;

	modport source(output valid, output root, input ready);
	modport sink(input valid, input root, output ready);
endinterface

// ===== rtl/isr_stage.sv =====
module isr_stage (
	input  logic [isr_pkg::PAD_WIDTH-1:0] x,
	input  logic [isr_pkg::REM_WIDTH-1:0] rem,
	input  logic [isr_pkg::ROOT_BITS-1:0] root,
	output logic [isr_pkg::PAD_WIDTH-1:0] x_nx,
	output logic [isr_pkg::REM_WIDTH-1:0] rem_nx,
	output logic [isr_pkg::ROOT_BITS-1:0] root_nx
);
	import isr_pkg::*;

	logic [REM_WIDTH-1:0] rem_shift;
	logic [REM_WIDTH-1:0] trial;
	logic [REM_WIDTH:0]   diff;
	logic                 fits;

	// Bring down the next two input bits and form the trial subtrahend 4*root + 1
	assign rem_shift = REM_WIDTH'({rem, x[PAD_WIDTH-1 -: 2]});
	assign trial     = REM_WIDTH'({root, 2'b01});
	assign diff      = {1'b0, rem_shift} - {1'b0, trial};
	assign fits      = ~diff[REM_WIDTH];

	// Keep the difference when the trial fits, and append the new root bit
	assign rem_nx  = fits ? diff[REM_WIDTH-1:0] : rem_shift;
	assign root_nx = ROOT_BITS'({root, fits});
	assign x_nx    = x << 2;

endmodule

// ===== rtl/integer_square_root_unit.sv =====
// Channel  | Dir | Payload                  | Notes
// ---------+-----+--------------------------+-------------------------------------
// operand  | in  | value [IN_WIDTH-1:0]      | unsigned, one transfer per item
// result   | out | root  [ROOT_WIDTH-1:0]    | floor square root, one per operand
//
// One root bit is settled per pipeline stage, and each stage registers its
// partial result on the way from operand transfer to result valid.
// Unless the result stalls, a new operand can enter every cycle (one item per cycle).
// Reset clears only the stage valid bits; payload registers are not reset.
// When the last stage holds a result that is not taken, the whole pipeline
// holds and operand ready drops; nothing is lost or repeated.
module integer_square_root_unit (
	input  logic             clk,
	input  logic             arst_n,
	isr_in_if.sink           operand,
	isr_out_if.source        result
);
	import isr_pkg::*;

	// Index k holds the registers that feed stage k; stage 0 takes the operand directly
	logic [ROOT_BITS:1]   valid_s;
	logic [ROOT_BITS:0]   valid_chain;
	logic [PAD_WIDTH-1:0] x_s    [ROOT_BITS];
	logic [REM_WIDTH-1:0] rem_s  [ROOT_BITS];
	logic [ROOT_BITS-1:0] root_s [ROOT_BITS+1];
	logic                 advance;

	// Advance the pipeline unless the final result is stalled
	assign advance       = ~valid_s[ROOT_BITS] | result.ready;
	assign operand.ready = advance;

	// Line up the operand valid with the stage valid bits
	assign valid_chain = {valid_s, operand.valid};

	// Move valid bits along with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (advance) begin
			valid_s <= valid_chain[ROOT_BITS-1:0];
		end
	end

	// One digit step per stage
	for (genvar k = 0; k < ROOT_BITS; k++) begin : g_stage
		logic [PAD_WIDTH-1:0] x_in;
		logic [REM_WIDTH-1:0] rem_in;
		logic [ROOT_BITS-1:0] root_in;
		logic [PAD_WIDTH-1:0] x_nx;
		logic [REM_WIDTH-1:0] rem_nx;
		logic [ROOT_BITS-1:0] root_nx;

		// Seed the recurrence with the padded operand, or take the previous stage
		if (k == 0) begin : g_seed
			assign x_in    = PAD_WIDTH'(operand.value);
			assign rem_in  = '0;
			assign root_in = '0;
		end else begin : g_chain
			assign x_in    = x_s[k];
			assign rem_in  = rem_s[k];
			assign root_in = root_s[k];
		end

		isr_stage u_stage (
			.x       (x_in),
			.rem     (rem_in),
			.root    (root_in),
			.x_nx    (x_nx),
			.rem_nx  (rem_nx),
			.root_nx (root_nx)
		);

		// Capture the partial root
		always_ff @(posedge clk) begin
			if (advance) begin
				root_s[k+1] <= root_nx;
			end
		end

		// Capture remainder and remaining input bits for the stages that follow
		if (k + 1 < ROOT_BITS) begin : g_carry
			always_ff @(posedge clk) begin
				if (advance) begin
					x_s[k+1]   <= x_nx;
					rem_s[k+1] <= rem_nx;
				end
			end
		end
	end

	// Drive the result from the last stage, clamping a root wider than the field
	assign result.valid = valid_s[ROOT_BITS];
	if (ROOT_BITS > ROOT_WIDTH) begin : g_sat
		assign result.root = (|root_s[ROOT_BITS][ROOT_BITS-1:ROOT_WIDTH])
			? {ROOT_WIDTH{1'b1}} : root_s[ROOT_BITS][ROOT_WIDTH-1:0];
	end else begin : g_ext
		assign result.root = ROOT_WIDTH'(root_s[ROOT_BITS]);
	end

endmodule

// ===== dv/integer_square_root_unit_tb.sv =====
module integer_square_root_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import isr_pkg::*;

	localparam int          RANDOM_ITEMS   = 750;
	localparam int          IDLE_PERCENT   = 11;
	localparam int          QUIET_FIRST    = 300;
	localparam int          QUIET_LAST     = 550;
	localparam int          WATCHDOG_LIMIT = 2000;
	localparam longint      VALUE_MAX      = (64'd1 << IN_WIDTH) - 1;

	// One operand, with the root typed in where it is known up front
	typedef struct packed {
		logic [IN_WIDTH-1:0]   value;
		logic                  known;
		logic [ROOT_WIDTH-1:0] root;
	} operand_row_t;

	localparam int DIRECTED_ROWS = 18;
	localparam operand_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{31'd0,          1'b1, 16'd0},
		'{31'd1,          1'b1, 16'd1},
		'{31'd2,          1'b1, 16'd1},
		'{31'd3,          1'b1, 16'd1},
		'{31'd4,          1'b1, 16'd2},
		'{31'd8,          1'b1, 16'd2},
		'{31'd9,          1'b1, 16'd3},
		'{31'h7FFFFFFF,   1'b1, 16'd46340},
		'{31'd2147395600, 1'b1, 16'd46340},
		'{31'd2147395599, 1'b1, 16'd46339},
		'{31'h40000000,   1'b1, 16'd32768},
		'{31'h3FFFFFFF,   1'b1, 16'd32767},
		'{31'h00010000,   1'b1, 16'd256},
		'{31'h0000FFFF,   1'b1, 16'd255},
		'{31'h55555555,   1'b0, 16'd0},
		'{31'h2AAAAAAA,   1'b0, 16'd0},
		'{31'h12345678,   1'b0, 16'd0},
		'{31'h7FFF0000,   1'b0, 16'd0}
	};

	logic clk;
	logic arst_n;

	isr_in_if  operand_ch();
	isr_out_if result_ch();

	integer_square_root_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.operand(operand_ch),
		.result (result_ch)
	);

	operand_row_t          pending_rows[$];
	operand_row_t          held_row;
	logic [ROOT_WIDTH-1:0] expected_roots[$];
	int                    mismatches  = 0;
	int                    cycle_count = 0;
	int                    idle_cycles = 0;

	// Floor square root, one result bit per step by trial subtraction
	function automatic logic [ROOT_WIDTH-1:0] floor_root(logic [IN_WIDTH-1:0] v);
		logic [63:0] rem;
		logic [63:0] acc;
		logic [63:0] probe;
		logic [63:0] trial;
		rem   = 64'(v);
		acc   = '0;
		probe = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			trial = acc + probe;
			if (rem >= trial) begin
				rem = rem - trial;
				acc = (acc >> 1) + probe;
			end else begin
				acc = acc >> 1;
			end
			probe = probe >> 2;
		end
		if (acc > 64'hFFFF)
			acc = 64'hFFFF;
		return acc[ROOT_WIDTH-1:0];
	endfunction

	// Idle at random, except inside the quiet stretch
	function automatic bit take_break();
		if (cycle_count >= QUIET_FIRST && cycle_count < QUIET_LAST)
			return 1'b0;
		return $urandom_range(99) < IDLE_PERCENT;
	endfunction

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Present operands; advance only after a transfer or while idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			operand_ch.valid <= 1'b0;
			operand_ch.value <= '0;
			held_row         <= '0;
		end else if (!operand_ch.valid || operand_ch.ready) begin
			if (pending_rows.size() != 0 && !take_break()) begin
				operand_ch.valid <= 1'b1;
				operand_ch.value <= pending_rows[0].value;
				held_row         <= pending_rows.pop_front();
			end else begin
				operand_ch.valid <= 1'b0;
			end
		end
	end

	// Stall the result side at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_ch.ready <= 1'b0;
		else
			result_ch.ready <= !take_break();
	end

	// Record expected roots on operand transfer, check them on result transfer
	always @(posedge clk) begin
		if (arst_n) begin
			cycle_count <= cycle_count + 1;
			if (operand_ch.valid && operand_ch.ready)
				expected_roots.push_back(held_row.known ? held_row.root
					: floor_root(operand_ch.value));
			if (result_ch.valid && result_ch.ready) begin
				if (expected_roots.size() == 0) begin
					$error("root: no result expected, actual %0d", result_ch.root);
					mismatches++;
				end else if (result_ch.root !== expected_roots[0]) begin
					$error("root mismatch: expected %0d, actual %0d",
						expected_roots[0], result_ch.root);
					mismatches++;
					void'(expected_roots.pop_front());
				end else begin
					void'(expected_roots.pop_front());
				end
			end
		end
	end

	// Drop the run when neither channel moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((operand_ch.valid && operand_ch.ready) || (result_ch.valid && result_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		operand_row_t row;
		longint       r;
		longint       v;
		int           sel;

		arst_n = 1'b0;

		// Directed rows first
		for (int i = 0; i < DIRECTED_ROWS; i++)
			pending_rows.push_back(DIRECTED[i]);

		// Random operands, some placed at edges of the root steps, near zero or near the top
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			sel = $urandom_range(9);
			case (sel)
				4: begin
					v = $urandom_range(300);
				end
				5, 6: begin
					r = $urandom_range(46340);
					v = r * r + longint'($urandom_range(2)) - 1;
				end
				7: begin
					v = longint'($urandom >> $urandom_range(31, 1));
				end
				8: begin
					v = VALUE_MAX - longint'($urandom_range(200000));
				end
				9: begin
					v = (longint'(1) << (2 * $urandom_range(15)))
						+ longint'($urandom_range(2)) - 1;
				end
				default: begin
					v = longint'($urandom);
				end
			endcase
			if (v < 0)
				v = 0;
			v = v & VALUE_MAX;
			row.value = v[IN_WIDTH-1:0];
			row.known = 1'b0;
			row.root  = '0;
			pending_rows.push_back(row);
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Hold until every operand has gone across and every root is back
		while (pending_rows.size() != 0 || operand_ch.valid)
			@(posedge clk);
		while (expected_roots.size() != 0)
			@(posedge clk);
		repeat (2 * ROOT_BITS) @(posedge clk);

		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
